>>> rtl/uct_pkg.sv
package uct_pkg;

  localparam logic [3:0] ENC_UTF8   = 4'd0;
  localparam logic [3:0] ENC_U16LE  = 4'd1;
  localparam logic [3:0] ENC_U16BE  = 4'd2;
  localparam logic [3:0] ENC_U16    = 4'd3;
  localparam logic [3:0] ENC_U32LE  = 4'd4;
  localparam logic [3:0] ENC_U32BE  = 4'd5;
  localparam logic [3:0] ENC_U32    = 4'd6;
  localparam logic [3:0] ENC_LATIN1 = 4'd7;
  localparam logic [3:0] ENC_LATIN9 = 4'd8;
  localparam logic [3:0] ENC_ASCII  = 4'd9;

  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_ILLEGAL = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_UNREP   = 3'd4;

  localparam logic [1:0] ACT_DATA  = 2'd0;
  localparam logic [1:0] ACT_END   = 2'd1;
  localparam logic [1:0] ACT_RESET = 2'd2;

  localparam logic [1:0] CFG_SRC = 2'd0;
  localparam logic [1:0] CFG_TGT = 2'd1;
  localparam logic [1:0] CFG_SUB = 2'd2;

  localparam logic [1:0] ORD_NONE = 2'd0;
  localparam logic [1:0] ORD_LE   = 2'd1;
  localparam logic [1:0] ORD_BE   = 2'd2;

  localparam logic [20:0] CP_MAX   = 21'h10FFFF;
  localparam logic [20:0] CP_PLANE = 21'h010000;
  localparam logic [20:0] CP_QMARK = 21'h00003F;

  typedef enum logic [1:0] {TK_ILL, TK_MORE, TK_CP, TK_MARK} take_t;

  typedef struct packed {
    logic [3:0] src;
    logic [3:0] tgt;
    logic       sub_en;
  } cfg_t;

  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      n;
    logic [2:0]      status;
    logic [15:0]     subs;
  } job_t;

  typedef struct packed {
    logic            ok;
    logic            mark;
    logic [3:0]      n;
    logic [7:0][7:0] bytes;
  } enc_t;

endpackage

>>> rtl/unicode_charset_transcoder.sv
// channel  direction  ports
// in       input      in_valid in_ready in_action in_byte
// out      output     out_valid out_ready out_byte out_status out_substitutions out_last
// cfg      input      cfg_valid cfg_ready cfg_index cfg_data
// an input item is decoded in the cycle of its transfer, one item per cycle while the queue is not full
// the output side gives one byte per cycle while out_ready is high, and an item has 1 to 8 bytes
// a two-entry queue sits between decoder and byte serialiser
// synchronous reset clears decoder, mark and counter state and empties the queue
// in_ready drops only while the queue is full
module unicode_charset_transcoder #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [2:0]  out_status,
  output logic [15:0] out_substitutions,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  uct_pkg::cfg_t cfg_r;
  uct_pkg::job_t wr_job, head;
  logic          full, empty, push, pop, take, src_wr;

  assign cfg_ready = 1'b1;
  assign in_ready = !full;
  assign take = in_valid && in_ready;
  assign src_wr = cfg_valid && (cfg_index == uct_pkg::CFG_SRC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        uct_pkg::CFG_SRC: cfg_r.src <= cfg_data;
        uct_pkg::CFG_TGT: cfg_r.tgt <= cfg_data;
        uct_pkg::CFG_SUB: cfg_r.sub_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  uct_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .src_wr(src_wr), .take(take),
    .action(in_action), .in_byte(in_byte), .push(push), .job(wr_job)
  );

  uct_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_job(wr_job), .pop(pop),
    .rd_job(head), .full(full), .empty(empty)
  );

  uct_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .empty(empty), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_status(out_status), .out_substitutions(out_substitutions), .out_last(out_last)
  );

endmodule

>>> rtl/uct_front.sv
module uct_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  uct_pkg::cfg_t   cfg,
  input  logic            src_wr,
  input  logic            take,
  input  logic [1:0]      action,
  input  logic [7:0]      in_byte,
  output logic            push,
  output uct_pkg::job_t   job
);

  logic [7:0]             held_r [6];
  logic [2:0]             hc_r, hc_nxt, exp_r, exp_nxt;
  logic [1:0]             ord_r, ord_nxt, ordv;
  logic                   mseen_r, mseen_nxt, omark_r, omark_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   wr_held, has_job, be;
  logic [7:0]             nb [6];
  logic [2:0]             nc;
  uct_pkg::take_t         tk;
  logic [20:0]            cp, v8;
  logic [15:0]            hi, lo;
  logic [31:0]            v32;
  uct_pkg::enc_t          er;

  function automatic uct_pkg::enc_t put_char(input logic [20:0] c, input logic [3:0] t,
                                             input logic om);
    uct_pkg::enc_t r;
    logic [19:0]   v;
    logic [15:0]   u0, u1;
    logic          b;
    int            m;
    r = '0;
    v = 20'(c - uct_pkg::CP_PLANE);
    u0 = 16'hD800 | {6'd0, v[19:10]};
    u1 = 16'hDC00 | {6'd0, v[9:0]};
    m = 0;
    case (t)
      uct_pkg::ENC_UTF8: begin
        r.ok = 1'b1;
        if (c < 21'h80) begin
          r.bytes[0] = c[7:0];
          r.n = 4'd1;
        end else if (c < 21'h800) begin
          r.bytes[0] = {3'b110, c[10:6]};
          r.bytes[1] = {2'b10, c[5:0]};
          r.n = 4'd2;
        end else if (c < 21'h10000) begin
          r.bytes[0] = {4'b1110, c[15:12]};
          r.bytes[1] = {2'b10, c[11:6]};
          r.bytes[2] = {2'b10, c[5:0]};
          r.n = 4'd3;
        end else begin
          r.bytes[0] = {5'b11110, c[20:18]};
          r.bytes[1] = {2'b10, c[17:12]};
          r.bytes[2] = {2'b10, c[11:6]};
          r.bytes[3] = {2'b10, c[5:0]};
          r.n = 4'd4;
        end
      end
      uct_pkg::ENC_U16LE, uct_pkg::ENC_U16BE, uct_pkg::ENC_U16: begin
        r.ok = 1'b1;
        b = (t == uct_pkg::ENC_U16BE);
        if (t == uct_pkg::ENC_U16 && !om) begin
          r.bytes[0] = 8'hFF;
          r.bytes[1] = 8'hFE;
          r.mark = 1'b1;
          m = 2;
        end
        if (c >= uct_pkg::CP_PLANE) begin
          r.bytes[m]   = b ? u0[15:8] : u0[7:0];
          r.bytes[m+1] = b ? u0[7:0] : u0[15:8];
          r.bytes[m+2] = b ? u1[15:8] : u1[7:0];
          r.bytes[m+3] = b ? u1[7:0] : u1[15:8];
          r.n = 4'(m + 4);
        end else begin
          r.bytes[m]   = b ? c[15:8] : c[7:0];
          r.bytes[m+1] = b ? c[7:0] : c[15:8];
          r.n = 4'(m + 2);
        end
      end
      uct_pkg::ENC_U32LE, uct_pkg::ENC_U32BE, uct_pkg::ENC_U32: begin
        r.ok = 1'b1;
        b = (t == uct_pkg::ENC_U32BE);
        if (t == uct_pkg::ENC_U32 && !om) begin
          r.bytes[0] = 8'hFF;
          r.bytes[1] = 8'hFE;
          r.mark = 1'b1;
          m = 4;
        end
        r.bytes[m]   = b ? 8'h00 : c[7:0];
        r.bytes[m+1] = b ? {3'd0, c[20:16]} : c[15:8];
        r.bytes[m+2] = b ? c[15:8] : {3'd0, c[20:16]};
        r.bytes[m+3] = b ? c[7:0] : 8'h00;
        r.n = 4'(m + 4);
      end
      uct_pkg::ENC_LATIN1: begin
        r.ok = (c <= 21'hFF);
        r.bytes[0] = c[7:0];
        r.n = 4'd1;
      end
      uct_pkg::ENC_LATIN9: begin
        r.n = 4'd1;
        r.ok = 1'b1;
        case (c)
          21'h20AC: r.bytes[0] = 8'hA4;
          21'h0160: r.bytes[0] = 8'hA6;
          21'h0161: r.bytes[0] = 8'hA8;
          21'h017D: r.bytes[0] = 8'hB4;
          21'h017E: r.bytes[0] = 8'hB8;
          21'h0152: r.bytes[0] = 8'hBC;
          21'h0153: r.bytes[0] = 8'hBD;
          21'h0178: r.bytes[0] = 8'hBE;
          default: begin
            r.bytes[0] = c[7:0];
            if (c > 21'hFF || c == 21'hA4 || c == 21'hA6 || c == 21'hA8 || c == 21'hB4 ||
                c == 21'hB8 || c == 21'hBC || c == 21'hBD || c == 21'hBE) begin
              r.ok = 1'b0;
            end
          end
        endcase
      end
      uct_pkg::ENC_ASCII: begin
        r.ok = (c <= 21'h7F);
        r.bytes[0] = c[7:0];
        r.n = 4'd1;
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    hc_nxt = hc_r;
    exp_nxt = exp_r;
    ord_nxt = ord_r;
    mseen_nxt = mseen_r;
    omark_nxt = omark_r;
    cnt_nxt = cnt_r;
    wr_held = 1'b0;
    has_job = 1'b0;
    tk = uct_pkg::TK_MORE;
    cp = '0;
    job = '0;
    er = '0;
    ordv = ord_r;
    be = 1'b0;
    nc = hc_r + 3'd1;
    for (int i = 0; i < 6; i++) begin
      nb[i] = (3'(i) == hc_r) ? in_byte : held_r[i];
    end
    case (exp_r)
      3'd2:    v8 = {10'd0, nb[0][4:0], nb[1][5:0]};
      3'd3:    v8 = {5'd0, nb[0][3:0], nb[1][5:0], nb[2][5:0]};
      default: v8 = {nb[0][2:0], nb[1][5:0], nb[2][5:0], nb[3][5:0]};
    endcase
    hi = 16'd0;
    lo = 16'd0;
    v32 = 32'd0;
    case (action)
      uct_pkg::ACT_END: begin
        has_job = 1'b1;
        job.n = 4'd1;
        job.status = (hc_r == 3'd0) ? uct_pkg::ST_END : uct_pkg::ST_TRUNC;
        hc_nxt = 3'd0;
        exp_nxt = 3'd0;
      end
      uct_pkg::ACT_RESET: begin
        hc_nxt = 3'd0;
        exp_nxt = 3'd0;
        ord_nxt = uct_pkg::ORD_NONE;
        mseen_nxt = 1'b0;
        omark_nxt = 1'b0;
      end
      uct_pkg::ACT_DATA: begin
        if (cfg.src == uct_pkg::ENC_UTF8) begin
          if (hc_r == 3'd0) begin
            if (in_byte < 8'h80) begin
              tk = uct_pkg::TK_CP;
              cp = {13'd0, in_byte};
            end else if (in_byte == 8'hC0 || in_byte == 8'hC1) begin
              tk = uct_pkg::TK_ILL;
            end else begin
              wr_held = 1'b1;
              hc_nxt = 3'd1;
              if (in_byte[7:5] == 3'b110) exp_nxt = 3'd2;
              else if (in_byte[7:4] == 4'b1110) exp_nxt = 3'd3;
              else if (in_byte[7:3] == 5'b11110) exp_nxt = 3'd4;
              else if (in_byte[7:2] == 6'b111110) exp_nxt = 3'd5;
              else if (in_byte[7:1] == 7'b1111110) exp_nxt = 3'd6;
              else tk = uct_pkg::TK_ILL;
            end
          end else if (in_byte[7:6] != 2'b10 || hc_r >= 3'd6) begin
            tk = uct_pkg::TK_ILL;
          end else begin
            wr_held = 1'b1;
            hc_nxt = nc;
            if (nc >= exp_r) begin
              if (exp_r > 3'd4 || (exp_r == 3'd2 && v8 < 21'h80) ||
                  (exp_r == 3'd3 && v8 < 21'h800) || (exp_r == 3'd4 && v8 < 21'h10000) ||
                  v8 > uct_pkg::CP_MAX || (v8 >= 21'hD800 && v8 <= 21'hDFFF)) begin
                tk = uct_pkg::TK_ILL;
              end else begin
                tk = uct_pkg::TK_CP;
                cp = v8;
              end
            end
          end
        end else if (cfg.src == uct_pkg::ENC_LATIN1 || cfg.src == uct_pkg::ENC_LATIN9 ||
                     cfg.src == uct_pkg::ENC_ASCII) begin
          tk = uct_pkg::TK_CP;
          cp = {13'd0, in_byte};
          if (cfg.src == uct_pkg::ENC_ASCII && in_byte > 8'h7F) tk = uct_pkg::TK_ILL;
          if (cfg.src == uct_pkg::ENC_LATIN9) begin
            case (in_byte)
              8'hA4:   cp = 21'h20AC;
              8'hA6:   cp = 21'h0160;
              8'hA8:   cp = 21'h0161;
              8'hB4:   cp = 21'h017D;
              8'hB8:   cp = 21'h017E;
              8'hBC:   cp = 21'h0152;
              8'hBD:   cp = 21'h0153;
              8'hBE:   cp = 21'h0178;
              default: cp = {13'd0, in_byte};
            endcase
          end
        end else if (cfg.src < uct_pkg::ENC_U16LE || cfg.src > uct_pkg::ENC_U32 ||
                     hc_r >= 3'd6) begin
          tk = uct_pkg::TK_ILL;
        end else begin
          wr_held = 1'b1;
          hc_nxt = nc;
          if (cfg.src <= uct_pkg::ENC_U16) begin
            if (nc >= 3'd2) begin
              if (nc == 3'd2 && cfg.src == uct_pkg::ENC_U16 && !mseen_r) begin
                mseen_nxt = 1'b1;
                if (nb[0] == 8'hFF && nb[1] == 8'hFE) begin
                  ordv = uct_pkg::ORD_LE;
                  tk = uct_pkg::TK_MARK;
                end else begin
                  ordv = uct_pkg::ORD_BE;
                  if (nb[0] == 8'hFE && nb[1] == 8'hFF) tk = uct_pkg::TK_MARK;
                end
                ord_nxt = ordv;
              end
              be = (cfg.src == uct_pkg::ENC_U16BE) ||
                   (cfg.src == uct_pkg::ENC_U16 && ordv != uct_pkg::ORD_LE);
              hi = be ? {nb[0], nb[1]} : {nb[1], nb[0]};
              lo = be ? {nb[2], nb[3]} : {nb[3], nb[2]};
              if (tk != uct_pkg::TK_MARK) begin
                if (nc == 3'd2) begin
                  if (hi[15:10] == 6'b110110) begin
                    exp_nxt = 3'd4;
                  end else if (hi[15:10] == 6'b110111) begin
                    tk = uct_pkg::TK_ILL;
                  end else begin
                    tk = uct_pkg::TK_CP;
                    cp = {5'd0, hi};
                  end
                end else if (nc >= 3'd4) begin
                  if (lo[15:10] != 6'b110111) begin
                    tk = uct_pkg::TK_ILL;
                  end else begin
                    tk = uct_pkg::TK_CP;
                    cp = {1'b0, hi[9:0], lo[9:0]} + uct_pkg::CP_PLANE;
                  end
                end
              end
            end
          end else if (nc >= 3'd4) begin
            if (cfg.src == uct_pkg::ENC_U32 && !mseen_r) begin
              mseen_nxt = 1'b1;
              if (nb[0] == 8'hFF && nb[1] == 8'hFE && nb[2] == 8'h00 && nb[3] == 8'h00) begin
                ordv = uct_pkg::ORD_LE;
                tk = uct_pkg::TK_MARK;
              end else begin
                ordv = uct_pkg::ORD_BE;
                if (nb[0] == 8'h00 && nb[1] == 8'h00 && nb[2] == 8'hFE && nb[3] == 8'hFF) begin
                  tk = uct_pkg::TK_MARK;
                end
              end
              ord_nxt = ordv;
            end
            be = (cfg.src == uct_pkg::ENC_U32BE) ||
                 (cfg.src == uct_pkg::ENC_U32 && ordv != uct_pkg::ORD_LE);
            v32 = be ? {nb[0], nb[1], nb[2], nb[3]} : {nb[3], nb[2], nb[1], nb[0]};
            if (tk != uct_pkg::TK_MARK) begin
              if (v32 > 32'h10FFFF || (v32 >= 32'hD800 && v32 <= 32'hDFFF)) begin
                tk = uct_pkg::TK_ILL;
              end else begin
                tk = uct_pkg::TK_CP;
                cp = v32[20:0];
              end
            end
          end
        end
        if (tk != uct_pkg::TK_MORE) begin
          hc_nxt = 3'd0;
          exp_nxt = 3'd0;
        end
        if (tk == uct_pkg::TK_ILL) begin
          has_job = 1'b1;
          job.n = 4'd1;
          job.status = uct_pkg::ST_ILLEGAL;
        end else if (tk == uct_pkg::TK_CP) begin
          has_job = 1'b1;
          er = put_char(cp, cfg.tgt, omark_r);
          if (!er.ok && cfg.sub_en) begin
            er = put_char(uct_pkg::CP_QMARK, cfg.tgt, omark_r);
            if (er.ok && cnt_r != '1) cnt_nxt = cnt_r + COUNT_WIDTH'(1);
          end
          if (er.ok) begin
            job.bytes = er.bytes;
            job.n = er.n;
            job.status = uct_pkg::ST_BYTE;
            omark_nxt = omark_r | er.mark;
          end else begin
            job.n = 4'd1;
            job.status = uct_pkg::ST_UNREP;
          end
        end
      end
      default: ;
    endcase
    job.subs = 16'(cnt_nxt);
  end

  assign push = take && has_job;

  always_ff @(posedge clk) begin
    if (take && wr_held) begin
      held_r[hc_r] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= 3'd0;
      exp_r <= 3'd0;
      ord_r <= uct_pkg::ORD_NONE;
      mseen_r <= 1'b0;
      omark_r <= 1'b0;
      cnt_r <= '0;
    end else if (src_wr) begin
      hc_r <= 3'd0;
      exp_r <= 3'd0;
    end else if (take) begin
      hc_r <= hc_nxt;
      exp_r <= exp_nxt;
      ord_r <= ord_nxt;
      mseen_r <= mseen_nxt;
      omark_r <= omark_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/uct_queue.sv
module uct_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uct_pkg::job_t wr_job,
  input  logic          pop,
  output uct_pkg::job_t rd_job,
  output logic          full,
  output logic          empty
);

  uct_pkg::job_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rd_job = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/uct_back.sv
module uct_back (
  input  logic          clk,
  input  logic          rst_n,
  input  uct_pkg::job_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [2:0]    out_status,
  output logic [15:0]   out_substitutions,
  output logic          out_last
);

  logic [2:0] idx_r, idx_nxt;

  assign out_valid = !empty;
  assign out_byte = head.bytes[idx_r];
  assign out_status = head.status;
  assign out_substitutions = head.subs;
  assign out_last = ({1'b0, idx_r} + 4'd1 == head.n);
  assign pop = out_valid && out_ready && out_last;

  always_comb begin
    idx_nxt = idx_r;
    if (out_valid && out_ready) begin
      idx_nxt = out_last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> rtl/uct_checker.sv
module uct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic [2:0]  out_status,
  input logic        out_last
);

  // status results stand alone
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != uct_pkg::ST_BYTE |-> out_last)
    else $error("status result not last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != uct_pkg::ST_BYTE |-> out_byte == 8'd0)
    else $error("status result carries a byte");

  // bytes of one character follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_status == uct_pkg::ST_BYTE)
    else $error("gap inside a character");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_status))
    else $error("stalled transfer changed");

endmodule

bind unicode_charset_transcoder uct_checker u_chk (.*);
